### src/indexed_sequence_list_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Indexed sequence list engine assertion macros
// Shared property forms for the checker of the list engine core.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_LIST_ENGINE_CORE_DEFINES_SVH
`define INDEXED_SEQUENCE_LIST_ENGINE_CORE_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define ISLE_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define ISLE_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/isle_pkg.sv
// ----------------------------------------------------------------------------
// Indexed sequence list engine package
// Field widths, operation codes, controller states and the command and
// status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package isle_pkg;

    localparam int OP_W   = 3;
    localparam int POS_W  = 8;
    localparam int DATA_W = 32;
    localparam int RPOS_W = 6;
    localparam int CNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT       = 3'd0,
        OP_REMOVE_AT    = 3'd1,
        OP_GET          = 3'd2,
        OP_SET          = 3'd3,
        OP_FIND         = 3'd4,
        OP_COUNT        = 3'd5,
        OP_REMOVE_VALUE = 3'd6,
        OP_CLEAR        = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PUT,
        S_UP_RD,
        S_UP_EV,
        S_GET_RD,
        S_GET_EV,
        S_DN_RD,
        S_DN_EV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        K_HOLD,
        K_IDX,
        K_LEN_M1,
        K_ZERO,
        K_INC,
        K_DEC
    } t_k_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_VAL
    } t_wr_sel;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC,
        LEN_CLR
    } t_len_op;

    typedef struct packed {
        logic    load;
        t_k_sel  k_sel;
        logic    rd;
        t_wr_sel wr_sel;
        logic    set_ok;
        logic    cap_rval;
        logic    cap_rpos;
        logic    cnt_inc;
        t_len_op len_op;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic idx_ok;
        logic idx_eq_len;
        logic len_zero;
        logic k_at_idx;
        logic k_at_last;
        logic match;
        logic out_free;
    } t_dp_status;

endpackage

### src/indexed_sequence_list_engine_core.sv
// ----------------------------------------------------------------------------
// Indexed sequence list engine core
// Ordered list of up to CAPACITY signed words with positional and
// value-based insert, remove, get, set, search, count and clear.
// ----------------------------------------------------------------------------
// A request enters on i_valid/o_stall with i_op, i_position and i_data_value.
// One result per request leaves on o_valid/i_stall and reports ok, a value,
// a position, a match count and the list length after the request.
// The block works on one request at a time. All entries sit in a single
// memory with one registered read and one write port, and every walk
// alternates a read state and an evaluate state for each entry it reads.
// Clear and any request that fails on its position or on a full list go
// straight to the result; set writes its entry; insert shifts up the
// entries from its position onward and then writes; get reads one
// entry; a search reads up to and including the match, or the whole
// list without one; count reads the whole list; a remove then also
// shifts the entries after the removed one down by one position.
// The next request is taken the cycle after its predecessor's result is
// registered, even while that result is still stalled at the output.
// A stalled result holds; a finished request waits for the output register.
// Reset empties the list and drops any result in flight. Entry contents are
// not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module indexed_sequence_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic        [isle_pkg::OP_W-1:0]     i_op,
    input  logic signed [isle_pkg::POS_W-1:0]    i_position,
    input  logic signed [isle_pkg::DATA_W-1:0]   i_data_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_ok,
    output logic signed [isle_pkg::DATA_W-1:0]   o_result_value,
    output logic        [isle_pkg::RPOS_W-1:0]   o_result_position,
    output logic        [isle_pkg::CNT_W-1:0]    o_match_count,
    output logic        [isle_pkg::CNT_W-1:0]    o_list_length
);

    isle_pkg::t_dp_cmd    cmd;
    isle_pkg::t_dp_status status;

    isle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    isle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_op              (i_op),
        .i_position        (i_position),
        .i_data_value      (i_data_value),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_ok              (o_ok),
        .o_result_value    (o_result_value),
        .o_result_position (o_result_position),
        .o_match_count     (o_match_count),
        .o_list_length     (o_list_length)
    );

endmodule

### src/isle_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed sequence list engine controller
// Sequences each request through resolve, scan, shift and write steps.
// ----------------------------------------------------------------------------
module isle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  isle_pkg::t_dp_status i_status,
    output isle_pkg::t_dp_cmd    o_cmd
);

    isle_pkg::t_state r_state;
    isle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != isle_pkg::S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.k_sel    = isle_pkg::K_HOLD;
        o_cmd.wr_sel   = isle_pkg::WR_NONE;
        o_cmd.len_op   = isle_pkg::LEN_HOLD;
        unique case (r_state)
            isle_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = isle_pkg::S_START;
                end
            end
            isle_pkg::S_START: begin
                unique case (i_status.op) inside
                    isle_pkg::OP_INSERT: begin
                        if (!i_status.idx_ok) begin
                            n_state = isle_pkg::S_DONE;
                        end else if (i_status.idx_eq_len) begin
                            n_state = isle_pkg::S_PUT;
                        end else begin
                            o_cmd.k_sel = isle_pkg::K_LEN_M1;
                            n_state     = isle_pkg::S_UP_RD;
                        end
                    end
                    isle_pkg::OP_REMOVE_AT, isle_pkg::OP_GET: begin
                        if (!i_status.idx_ok) begin
                            n_state = isle_pkg::S_DONE;
                        end else begin
                            o_cmd.k_sel = isle_pkg::K_IDX;
                            n_state     = isle_pkg::S_GET_RD;
                        end
                    end
                    isle_pkg::OP_SET: begin
                        n_state = i_status.idx_ok ? isle_pkg::S_PUT : isle_pkg::S_DONE;
                    end
                    isle_pkg::OP_FIND, isle_pkg::OP_COUNT, isle_pkg::OP_REMOVE_VALUE: begin
                        o_cmd.set_ok = (i_status.op == isle_pkg::OP_COUNT);
                        if (i_status.len_zero) begin
                            n_state = isle_pkg::S_DONE;
                        end else begin
                            o_cmd.k_sel = isle_pkg::K_ZERO;
                            n_state     = isle_pkg::S_SCAN_RD;
                        end
                    end
                    default: begin
                        o_cmd.set_ok = 1'b1;
                        o_cmd.len_op = isle_pkg::LEN_CLR;
                        n_state      = isle_pkg::S_DONE;
                    end
                endcase
            end
            isle_pkg::S_PUT: begin
                o_cmd.wr_sel = isle_pkg::WR_VAL;
                o_cmd.set_ok = 1'b1;
                if (i_status.op == isle_pkg::OP_INSERT) begin
                    o_cmd.len_op = isle_pkg::LEN_INC;
                end
                n_state = isle_pkg::S_DONE;
            end
            isle_pkg::S_UP_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = isle_pkg::S_UP_EV;
            end
            isle_pkg::S_UP_EV: begin
                o_cmd.wr_sel = isle_pkg::WR_UP;
                if (i_status.k_at_idx) begin
                    n_state = isle_pkg::S_PUT;
                end else begin
                    o_cmd.k_sel = isle_pkg::K_DEC;
                    n_state     = isle_pkg::S_UP_RD;
                end
            end
            isle_pkg::S_GET_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = isle_pkg::S_GET_EV;
            end
            isle_pkg::S_GET_EV: begin
                o_cmd.cap_rval = 1'b1;
                o_cmd.set_ok   = 1'b1;
                if (i_status.op != isle_pkg::OP_REMOVE_AT) begin
                    n_state = isle_pkg::S_DONE;
                end else if (i_status.k_at_last) begin
                    o_cmd.len_op = isle_pkg::LEN_DEC;
                    n_state      = isle_pkg::S_DONE;
                end else begin
                    o_cmd.k_sel = isle_pkg::K_INC;
                    n_state     = isle_pkg::S_DN_RD;
                end
            end
            isle_pkg::S_DN_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = isle_pkg::S_DN_EV;
            end
            isle_pkg::S_DN_EV: begin
                o_cmd.wr_sel = isle_pkg::WR_DOWN;
                if (i_status.k_at_last) begin
                    o_cmd.len_op = isle_pkg::LEN_DEC;
                    n_state      = isle_pkg::S_DONE;
                end else begin
                    o_cmd.k_sel = isle_pkg::K_INC;
                    n_state     = isle_pkg::S_DN_RD;
                end
            end
            isle_pkg::S_SCAN_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = isle_pkg::S_SCAN_EV;
            end
            isle_pkg::S_SCAN_EV: begin
                if (i_status.op == isle_pkg::OP_COUNT) begin
                    o_cmd.cnt_inc = 1'b1;
                    if (i_status.k_at_last) begin
                        n_state = isle_pkg::S_DONE;
                    end else begin
                        o_cmd.k_sel = isle_pkg::K_INC;
                        n_state     = isle_pkg::S_SCAN_RD;
                    end
                end else if (i_status.match) begin
                    o_cmd.set_ok   = 1'b1;
                    o_cmd.cap_rpos = 1'b1;
                    if (i_status.op != isle_pkg::OP_REMOVE_VALUE) begin
                        n_state = isle_pkg::S_DONE;
                    end else if (i_status.k_at_last) begin
                        o_cmd.len_op = isle_pkg::LEN_DEC;
                        n_state      = isle_pkg::S_DONE;
                    end else begin
                        o_cmd.k_sel = isle_pkg::K_INC;
                        n_state     = isle_pkg::S_DN_RD;
                    end
                end else if (i_status.k_at_last) begin
                    n_state = isle_pkg::S_DONE;
                end else begin
                    o_cmd.k_sel = isle_pkg::K_INC;
                    n_state     = isle_pkg::S_SCAN_RD;
                end
            end
            isle_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = isle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### src/isle_dp.sv
// ----------------------------------------------------------------------------
// Indexed sequence list engine datapath
// Entry memory, position resolution, walk counter, comparator, result
// accumulation and the output register.
// ----------------------------------------------------------------------------
module isle_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  isle_pkg::t_dp_cmd                    i_cmd,
    output isle_pkg::t_dp_status                 o_status,
    input  logic        [isle_pkg::OP_W-1:0]     i_op,
    input  logic signed [isle_pkg::POS_W-1:0]    i_position,
    input  logic signed [isle_pkg::DATA_W-1:0]   i_data_value,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic                                 o_ok,
    output logic signed [isle_pkg::DATA_W-1:0]   o_result_value,
    output logic        [isle_pkg::RPOS_W-1:0]   o_result_position,
    output logic        [isle_pkg::CNT_W-1:0]    o_match_count,
    output logic        [isle_pkg::CNT_W-1:0]    o_list_length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int SW = ((LW > isle_pkg::POS_W) ? LW : isle_pkg::POS_W) + 2;
    localparam int PW = (AW > isle_pkg::RPOS_W) ? AW : isle_pkg::RPOS_W;
    localparam int CW = (LW > isle_pkg::CNT_W) ? LW : isle_pkg::CNT_W;
    localparam logic signed [SW-1:0] ONE_S = 1;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    logic [isle_pkg::DATA_W-1:0] r_mem [CAPACITY];

    logic [LW-1:0]               r_len;
    logic [LW-1:0]               n_len;
    isle_pkg::t_op               r_op;
    logic [isle_pkg::DATA_W-1:0] r_val;
    logic [AW-1:0]               r_idx;
    logic                        r_idx_ok;
    logic                        r_idx_eq_len;
    logic [AW-1:0]               r_k;
    logic [AW-1:0]               n_k;
    logic [isle_pkg::DATA_W-1:0] r_rdata;
    logic                        r_ok;
    logic [isle_pkg::DATA_W-1:0] r_rval;
    logic [AW-1:0]               r_rpos;
    logic [LW-1:0]               r_cnt;

    logic                        r_out_valid;
    logic                        r_out_ok;
    logic [isle_pkg::DATA_W-1:0] r_out_rval;
    logic [AW-1:0]               r_out_rpos;
    logic [LW-1:0]               r_out_cnt;
    logic [LW-1:0]               r_out_len;

    logic signed [SW-1:0] pos_s;
    logic signed [SW-1:0] len_s;
    logic signed [SW-1:0] ins_idx;
    logic signed [SW-1:0] acc_idx;
    logic signed [SW-1:0] sel_idx;
    logic                 ins_ok;
    logic                 acc_ok;
    logic                 is_insert;
    logic [LW-1:0]        len_m1;
    logic                 match;
    logic                 out_free;
    logic [PW-1:0]        rpos_ext;
    logic [CW-1:0]        cnt_ext;
    logic [CW-1:0]        len_ext;

    assign is_insert = (isle_pkg::t_op'(i_op) == isle_pkg::OP_INSERT);
    assign pos_s     = SW'(i_position);
    assign len_s     = $signed({{(SW - LW){1'b0}}, r_len});
    assign ins_idx   = (pos_s < 0) ? (pos_s + len_s + ONE_S) : pos_s;
    assign acc_idx   = (pos_s < 0) ? (pos_s + len_s) : pos_s;
    assign ins_ok    = (ins_idx >= 0) && (ins_idx <= len_s) && (r_len < CAP_L);
    assign acc_ok    = (acc_idx >= 0) && (acc_idx < len_s);
    assign sel_idx   = is_insert ? ins_idx : acc_idx;

    assign len_m1   = r_len - LW'(1);
    assign match    = (r_rdata == r_val);
    assign out_free = !r_out_valid || !i_stall;

    assign o_status.op         = r_op;
    assign o_status.idx_ok     = r_idx_ok;
    assign o_status.idx_eq_len = r_idx_eq_len;
    assign o_status.len_zero   = (r_len == '0);
    assign o_status.k_at_idx   = (r_k == r_idx);
    assign o_status.k_at_last  = (LW'(r_k) == len_m1);
    assign o_status.match      = match;
    assign o_status.out_free   = out_free;

    always_comb begin
        unique case (i_cmd.k_sel)
            isle_pkg::K_IDX:    n_k = r_idx;
            isle_pkg::K_LEN_M1: n_k = len_m1[AW-1:0];
            isle_pkg::K_ZERO:   n_k = '0;
            isle_pkg::K_INC:    n_k = r_k + AW'(1);
            isle_pkg::K_DEC:    n_k = r_k - AW'(1);
            default:            n_k = r_k;
        endcase
    end

    always_comb begin
        unique case (i_cmd.len_op)
            isle_pkg::LEN_INC: n_len = r_len + LW'(1);
            isle_pkg::LEN_DEC: n_len = len_m1;
            isle_pkg::LEN_CLR: n_len = '0;
            default:           n_len = r_len;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (i_cmd.load) begin
            r_op         <= isle_pkg::t_op'(i_op);
            r_val        <= i_data_value;
            r_idx        <= sel_idx[AW-1:0];
            r_idx_ok     <= is_insert ? ins_ok : acc_ok;
            r_idx_eq_len <= (ins_idx == len_s);
            r_ok         <= 1'b0;
            r_rval       <= '0;
            r_rpos       <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cmd.set_ok) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.cap_rval && (r_op == isle_pkg::OP_REMOVE_AT || r_op == isle_pkg::OP_GET)) begin
                r_rval <= r_rdata;
            end
            if (i_cmd.cap_rpos) begin
                r_rpos <= r_k;
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + LW'(match);
            end
        end
        if (i_cmd.out_load) begin
            r_out_ok   <= r_ok;
            r_out_rval <= r_rval;
            r_out_rpos <= r_rpos;
            r_out_cnt  <= r_cnt;
            r_out_len  <= r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_k];
        end
        unique case (i_cmd.wr_sel)
            isle_pkg::WR_UP:   r_mem[r_k + AW'(1)] <= r_rdata;
            isle_pkg::WR_DOWN: r_mem[r_k - AW'(1)] <= r_rdata;
            isle_pkg::WR_VAL:  r_mem[r_idx] <= r_val;
            default: begin
            end
        endcase
    end

    assign rpos_ext = PW'(r_out_rpos);
    assign cnt_ext  = CW'(r_out_cnt);
    assign len_ext  = CW'(r_out_len);

    assign o_valid           = r_out_valid;
    assign o_ok              = r_out_ok;
    assign o_result_value    = r_out_rval;
    assign o_result_position = rpos_ext[isle_pkg::RPOS_W-1:0];
    assign o_match_count     = cnt_ext[isle_pkg::CNT_W-1:0];
    assign o_list_length     = len_ext[isle_pkg::CNT_W-1:0];

endmodule

### src/isle_checker.sv
// ----------------------------------------------------------------------------
// Indexed sequence list engine checker
// Port-level properties of the list engine core, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_sequence_list_engine_core_defines.svh"

module isle_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic        [isle_pkg::OP_W-1:0]     i_op,
    input logic signed [isle_pkg::POS_W-1:0]    i_position,
    input logic signed [isle_pkg::DATA_W-1:0]   i_data_value,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic                                 o_ok,
    input logic signed [isle_pkg::DATA_W-1:0]   o_result_value,
    input logic        [isle_pkg::RPOS_W-1:0]   o_result_position,
    input logic        [isle_pkg::CNT_W-1:0]    o_match_count,
    input logic        [isle_pkg::CNT_W-1:0]    o_list_length
);

    `ISLE_ASSERT_NEXT(a_one_request_in_flight, i_valid && !o_stall, o_stall, "second request accepted while one is in progress")

    `ISLE_ASSERT_NOW(a_length_bounded, o_valid, o_list_length <= CAPACITY, "reported length exceeds capacity")

    `ISLE_ASSERT_NOW(a_failed_result_clean, o_valid && !o_ok, o_result_value == 0 && o_result_position == 0 && o_match_count == 0, "failed request reports nonzero fields")

    `ISLE_ASSERT_NEXT(a_stalled_result_holds, o_valid && i_stall, o_valid && $stable(o_result_value) && $stable(o_list_length), "stalled result changed")

endmodule

bind indexed_sequence_list_engine_core isle_checker #(.CAPACITY(CAPACITY)) u_isle_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed sequence list engine testbench
// Drives insert, remove, get, set, search, count and clear requests into the
// list engine core with random gaps and output stalls. A behavioral copy of
// the list predicts every result, and each result is checked field by field
// in request order.
// ----------------------------------------------------------------------------
module testbench;
    import isle_pkg::*;

    localparam int LIST_CAP = 64;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] value;
        logic        [RPOS_W-1:0] position;
        logic        [CNT_W-1:0]  count;
        logic        [CNT_W-1:0]  length;
    } list_result_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic        [OP_W-1:0]   i_op;
    logic signed [POS_W-1:0]  i_position;
    logic signed [DATA_W-1:0] i_data_value;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_ok;
    logic signed [DATA_W-1:0] o_result_value;
    logic        [RPOS_W-1:0] o_result_position;
    logic        [CNT_W-1:0]  o_match_count;
    logic        [CNT_W-1:0]  o_list_length;

    list_result_t             pending_results[$];
    logic signed [DATA_W-1:0] list_mem[LIST_CAP];
    int                       list_len;
    int                       error_count;
    int                       results_checked;
    int                       requests_sent;
    int                       full_inserts;
    int                       op_counts[8];
    bit                       sender_quiet;

    indexed_sequence_list_engine_core #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_op(i_op),
        .i_position(i_position),
        .i_data_value(i_data_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_ok(o_ok),
        .o_result_value(o_result_value),
        .o_result_position(o_result_position),
        .o_match_count(o_match_count),
        .o_list_length(o_list_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic list_result_t predict_list_result(t_op op,
                                                         logic signed [POS_W-1:0] pos,
                                                         logic signed [DATA_W-1:0] val);
        list_result_t res;
        int           p;
        int           ins_idx;
        int           at_idx;
        int           hit;
        int           k;
        bit           at_ok;
        res = '{default: '0};
        p = pos;
        ins_idx = (p < 0) ? p + list_len + 1 : p;
        at_idx = (p < 0) ? p + list_len : p;
        at_ok = (at_idx >= 0) && (at_idx < list_len);
        hit = -1;
        case (op)
            OP_INSERT: begin
                if (ins_idx >= 0 && ins_idx <= list_len && list_len < LIST_CAP) begin
                    for (k = list_len; k > ins_idx; k--) list_mem[k] = list_mem[k-1];
                    list_mem[ins_idx] = val;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (at_ok) begin
                    res.value = list_mem[at_idx];
                    for (k = at_idx; k < list_len - 1; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            OP_GET: begin
                if (at_ok) begin
                    res.value = list_mem[at_idx];
                    res.ok = 1'b1;
                end
            end
            OP_SET: begin
                if (at_ok) begin
                    list_mem[at_idx] = val;
                    res.ok = 1'b1;
                end
            end
            OP_FIND, OP_REMOVE_VALUE: begin
                for (k = 0; k < list_len && hit < 0; k++) begin
                    if (list_mem[k] === val) hit = k;
                end
                if (hit >= 0) begin
                    res.ok = 1'b1;
                    res.position = hit[RPOS_W-1:0];
                    if (op == OP_REMOVE_VALUE) begin
                        for (k = hit; k < list_len - 1; k++) list_mem[k] = list_mem[k+1];
                        list_len--;
                    end
                end
            end
            OP_COUNT: begin
                for (k = 0; k < list_len; k++) begin
                    if (list_mem[k] === val) res.count++;
                end
                res.ok = 1'b1;
            end
            default: begin
                list_len = 0;
                res.ok = 1'b1;
            end
        endcase
        res.length = list_len[CNT_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position(int limit);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r >= 90) begin
            k = $urandom_range(0, 255);
            return k[POS_W-1:0];
        end
        k = (r < 78 && limit > 0) ? $urandom_range(0, limit - 1) : limit + $urandom_range(0, 2);
        if ($urandom_range(0, 1)) k = -(k + 1);
        return k[POS_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] pool[8];
        int                       r;
        pool = '{0, -1, 1, 32'sh7fffffff, 32'sh80000000, 5, 7, 42};
        r = $urandom_range(0, 99);
        if (r < 40 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
        if (r < 70) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic report_mismatch(string msg);
        $display("Mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_request(t_op op, logic signed [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
        int gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_position   <= pos;
        i_data_value <= val;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_list_result(op, pos, val));
        requests_sent++;
        op_counts[op]++;
        if (requests_sent % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_random_request(int insert_w, int remove_w);
        t_op op;
        int  r;
        r = $urandom_range(0, 99);
        if (r < insert_w) begin
            op = OP_INSERT;
        end else if (r < insert_w + remove_w) begin
            op = $urandom_range(0, 1) ? OP_REMOVE_AT : OP_REMOVE_VALUE;
        end else if (r >= 98) begin
            op = OP_CLEAR;
        end else begin
            case ($urandom_range(0, 3))
                0: op = OP_GET;
                1: op = OP_SET;
                2: op = OP_FIND;
                default: op = OP_COUNT;
            endcase
        end
        if (op == OP_INSERT && list_len == LIST_CAP) full_inserts++;
        send_request(op, pick_position(op == OP_INSERT ? list_len + 1 : list_len), pick_value());
    endtask

    task automatic test_empty_list();
        send_request(OP_GET, 0, 0);
        send_request(OP_REMOVE_AT, -1, 0);
        send_request(OP_SET, 0, 9);
        send_request(OP_FIND, 0, 0);
        send_request(OP_REMOVE_VALUE, 0, 0);
        send_request(OP_COUNT, 0, 0);
    endtask

    task automatic test_insert_positions();
        send_request(OP_INSERT, -1, 32'sh80000000);
        send_request(OP_INSERT, 0, 32'sh7fffffff);
        send_request(OP_INSERT, 2, -1);
        send_request(OP_INSERT, 4, 3);
        send_request(OP_INSERT, -5, 3);
        send_request(OP_INSERT, -4, 5);
        send_request(OP_INSERT, 127, 3);
        send_request(OP_INSERT, -128, 3);
    endtask

    task automatic test_access_positions();
        send_request(OP_GET, -1, 0);
        send_request(OP_GET, -4, 0);
        send_request(OP_GET, -5, 0);
        send_request(OP_GET, 4, 0);
        send_request(OP_SET, 1, 0);
        send_request(OP_SET, -128, 1);
        send_request(OP_GET, 1, 0);
        send_request(OP_REMOVE_AT, -1, 0);
    endtask

    task automatic test_search_ops();
        send_request(OP_FIND, 0, 32'sh80000000);
        send_request(OP_REMOVE_VALUE, 0, 5);
        send_request(OP_COUNT, 0, 0);
        send_request(OP_FIND, 0, 12345);
    endtask

    task automatic test_clear();
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_GET, 0, 0);
        send_request(OP_COUNT, 0, 0);
    endtask

    task automatic test_random_mix();
        repeat (350) send_random_request(30, 25);
    endtask

    task automatic test_fill_and_drain();
        int stop_at;
        stop_at = requests_sent + 400;
        while (requests_sent < stop_at) begin
            while (list_len < LIST_CAP && requests_sent < stop_at) send_random_request(80, 5);
            repeat (8) send_random_request(30, 0);
            while (list_len > 0 && requests_sent < stop_at) send_random_request(5, 75);
        end
    endtask

    initial begin
        int stall_left;
        int quiet_left;
        bit out_quiet;
        stall_left = 0;
        quiet_left = 0;
        out_quiet = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet_left == 0) begin
                out_quiet = ($urandom_range(0, 3) == 0);
                quiet_left = 300;
            end else begin
                quiet_left--;
            end
            if (stall_left > 0) stall_left--;
            else if (!out_quiet) stall_left = pick_gap();
            i_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin : check_results
        list_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_ok !== want.ok)
                    report_mismatch($sformatf("ok got %0b expected %0b", o_ok, want.ok));
                if (o_result_value !== want.value)
                    report_mismatch($sformatf("result_value got %0d expected %0d",
                                              o_result_value, want.value));
                if (o_result_position !== want.position)
                    report_mismatch($sformatf("result_position got %0d expected %0d",
                                              o_result_position, want.position));
                if (o_match_count !== want.count)
                    report_mismatch($sformatf("match_count got %0d expected %0d",
                                              o_match_count, want.count));
                if (o_list_length !== want.length)
                    report_mismatch($sformatf("list_length got %0d expected %0d",
                                              o_list_length, want.length));
            end
        end
    end

    initial begin
        list_len = 0;
        error_count = 0;
        results_checked = 0;
        requests_sent = 0;
        full_inserts = 0;
        sender_quiet = 1'b0;
        foreach (op_counts[n]) op_counts[n] = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_op         <= OP_INSERT;
        i_position   <= '0;
        i_data_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_insert_positions();
        test_access_positions();
        test_search_ops();
        test_clear();
        test_random_mix();
        test_fill_and_drain();

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Checked %0d results of %0d requests: %0d inserts, %0d positional removes,",
                 results_checked, requests_sent, op_counts[OP_INSERT], op_counts[OP_REMOVE_AT]);
        $display("%0d value removes, %0d finds, %0d counts, %0d clears, %0d inserts on a full list.",
                 op_counts[OP_REMOVE_VALUE], op_counts[OP_FIND], op_counts[OP_COUNT],
                 op_counts[OP_CLEAR], full_inserts);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
